// ===== rtl/core/bmhq_pkg.sv =====
// Shared constants, codes and entry type for the binary min-heap queue.
// No dependencies; compile first.
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int CAPACITY     = 256;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CHD_BITS = IDX_BITS + 2;

  localparam int STATUS_BITS = 2;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [PAYLOAD_BITS-1:0]    payload;
  } entry_t;

endpackage

// ===== rtl/core/bmhq_if.sv =====
// Valid/ready channel interfaces for the heap queue command and result items.
// Depends on bmhq_pkg.
`timescale 1ns / 1ps

interface bmhq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic signed [bmhq_pkg::KEY_BITS-1:0] key;
  logic [bmhq_pkg::PAYLOAD_BITS-1:0]    payload;

  modport source (output valid, output cmd, output key, output payload, input ready);
  modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

interface bmhq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [bmhq_pkg::STATUS_BITS-1:0]     status;
  logic signed [bmhq_pkg::KEY_BITS-1:0] out_key;
  logic [bmhq_pkg::PAYLOAD_BITS-1:0]    out_payload;
  logic                                 now_empty;

  modport source (output valid, output status, output out_key, output out_payload,
                  output now_empty, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input now_empty, output ready);
endinterface

// ===== rtl/core/binary_min_heap_queue_unit.sv =====
// Binary min-heap priority queue: entry store in one two-read/one-write memory.
// Depends on bmhq_pkg and the bmhq_in_if / bmhq_out_if interfaces.
//
//   channel   dir  payload                               handshake
//   in_ch     in   cmd, key, payload                     valid/ready
//   out_ch    out  status, out_key, out_payload, now_empty valid/ready
//
// One item at a time. Insert: read the parent, compare, and move it down while the new key is
// smaller, then write the new entry. Extract: load the root and the last entry, read both
// children and move the smaller one up while its key is below the moved entry's, then write it.
// Refused items (full or empty) go straight to the result. Reset empties the heap. in_ch.ready
// rises with out_ch.valid, so the next item is taken while the last result still waits; a
// stalled out_ch holds the next one.
`timescale 1ns / 1ps

module binary_min_heap_queue_unit (
  input logic       clk,
  input logic       rst_n,
  bmhq_in_if.sink   in_ch,
  bmhq_out_if.source out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_EX_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_WRITE,
    ST_DONE
  } state_t;

  bmhq_pkg::entry_t mem [bmhq_pkg::CAPACITY];
  bmhq_pkg::entry_t rdata_a_r, rdata_b_r;

  state_t                             state_r, state_nxt;
  logic [bmhq_pkg::CNT_BITS-1:0]      count_r, count_nxt;
  logic [bmhq_pkg::CNT_BITS-1:0]      last_r, last_nxt;
  logic [bmhq_pkg::IDX_BITS-1:0]      i_r, i_nxt;
  logic                               ins_r, ins_nxt;
  bmhq_pkg::entry_t                   ent_r, ent_nxt;
  logic [bmhq_pkg::STATUS_BITS-1:0]   res_status_r, res_status_nxt;
  bmhq_pkg::entry_t                   res_ent_r, res_ent_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [bmhq_pkg::STATUS_BITS-1:0]   out_status_r, out_status_nxt;
  bmhq_pkg::entry_t                   out_ent_r, out_ent_nxt;
  logic                               out_empty_r, out_empty_nxt;

  logic                               mem_we;
  logic [bmhq_pkg::IDX_BITS-1:0]      wr_addr, rd_addr_a, rd_addr_b;
  bmhq_pkg::entry_t                   wr_data;

  logic [bmhq_pkg::IDX_BITS-1:0]      parent;
  logic [bmhq_pkg::CHD_BITS-1:0]      lc, rc, last_x;
  logic                               pick_right;
  bmhq_pkg::entry_t                   pick_ent;
  logic [bmhq_pkg::IDX_BITS-1:0]      pick_idx;

  assign parent     = (i_r - 1'b1) >> 1;
  assign lc         = {1'b0, i_r, 1'b1};
  assign rc         = lc + 1'b1;
  assign last_x     = bmhq_pkg::CHD_BITS'(last_r);
  assign pick_right = (rc < last_x) && (rdata_b_r.key < rdata_a_r.key);
  assign pick_ent   = pick_right ? rdata_b_r : rdata_a_r;
  assign pick_idx   = pick_right ? rc[bmhq_pkg::IDX_BITS-1:0] : lc[bmhq_pkg::IDX_BITS-1:0];

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_key     = out_ent_r.key;
  assign out_ch.out_payload = out_ent_r.payload;
  assign out_ch.now_empty   = out_empty_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_nxt       = last_r;
    i_nxt          = i_r;
    ins_nxt        = ins_r;
    ent_nxt        = ent_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_empty_nxt  = out_empty_r;
    mem_we         = 1'b0;
    wr_addr        = i_r;
    wr_data        = ent_r;
    rd_addr_a      = '0;
    rd_addr_b      = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_status_nxt = bmhq_pkg::STATUS_OK;
          res_ent_nxt    = '0;
          if (in_ch.cmd == bmhq_pkg::CMD_INSERT) begin
            ins_nxt = 1'b1;
            if (count_r >= bmhq_pkg::CNT_BITS'(bmhq_pkg::CAPACITY)) begin
              res_status_nxt = bmhq_pkg::STATUS_FULL;
              state_nxt      = ST_DONE;
            end else begin
              ent_nxt.key     = in_ch.key;
              ent_nxt.payload = in_ch.payload;
              i_nxt           = count_r[bmhq_pkg::IDX_BITS-1:0];
              state_nxt       = ST_UP_RD;
            end
          end else begin
            ins_nxt = 1'b0;
            if (count_r == '0) begin
              res_status_nxt = bmhq_pkg::STATUS_EMPTY;
              state_nxt      = ST_DONE;
            end else begin
              last_nxt  = count_r - 1'b1;
              rd_addr_a = '0;
              rd_addr_b = last_nxt[bmhq_pkg::IDX_BITS-1:0];
              state_nxt = ST_EX_LD;
            end
          end
        end
      end
      ST_UP_RD: begin
        if (i_r == '0) begin
          state_nxt = ST_WRITE;
        end else begin
          rd_addr_a = parent;
          state_nxt = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (ent_r.key < rdata_a_r.key) begin
          mem_we    = 1'b1;
          wr_data   = rdata_a_r;
          i_nxt     = parent;
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_EX_LD: begin
        res_ent_nxt = rdata_a_r;
        ent_nxt     = rdata_b_r;
        i_nxt       = '0;
        state_nxt   = ST_DN_RD;
      end
      ST_DN_RD: begin
        if (lc < last_x) begin
          rd_addr_a = lc[bmhq_pkg::IDX_BITS-1:0];
          rd_addr_b = rc[bmhq_pkg::IDX_BITS-1:0];
          state_nxt = ST_DN_CMP;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_DN_CMP: begin
        if (pick_ent.key < ent_r.key) begin
          mem_we    = 1'b1;
          wr_data   = pick_ent;
          i_nxt     = pick_idx;
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        count_nxt = ins_r ? count_r + 1'b1 : last_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ent_nxt    = res_ent_r;
          out_empty_nxt  = (count_r == '0);
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a_r <= mem[rd_addr_a];
    rdata_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    last_r       <= last_nxt;
    i_r          <= i_nxt;
    ins_r        <= ins_nxt;
    ent_r        <= ent_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_empty_r  <= out_empty_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bmhq_pkg::CNT_BITS'(bmhq_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> $past(state_r) == ST_WRITE)
    else $error("entry count changed outside write-back");

  a_empty_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && (res_status_r == bmhq_pkg::STATUS_EMPTY) |-> count_r == '0)
    else $error("empty status with entries present");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> bmhq_pkg::CNT_BITS'(wr_addr) <= count_r)
    else $error("write beyond heap end");
`endif

endmodule

// ===== bench/tb_binary_min_heap_queue_unit.sv =====
// Self-checking bench for binary_min_heap_queue_unit: random insert/extract items with
// random idling on both channels, checked against a shadow heap held in a small class.
// Depends on bmhq_pkg, bmhq_in_if / bmhq_out_if and the heap queue RTL.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue_unit;

  typedef struct {
    logic [bmhq_pkg::STATUS_BITS-1:0]     status;
    logic signed [bmhq_pkg::KEY_BITS-1:0] key;
    logic [bmhq_pkg::PAYLOAD_BITS-1:0]    payload;
    logic                                 now_empty;
  } heap_reply_t;

  class heap_shadow;
    bmhq_pkg::entry_t slots[bmhq_pkg::CAPACITY];
    int               fill;
    heap_reply_t      replies_due[$];
    int               errors;
    int               n_insert, n_extract, n_full, n_empty, peak_fill;

    function new();
      fill = 0;
      errors = 0;
      n_insert = 0;
      n_extract = 0;
      n_full = 0;
      n_empty = 0;
      peak_fill = 0;
    endfunction

    function void note_command(logic cmd, logic signed [bmhq_pkg::KEY_BITS-1:0] key,
                               logic [bmhq_pkg::PAYLOAD_BITS-1:0] payload);
      heap_reply_t      r;
      bmhq_pkg::entry_t moving;
      int               i, up, last, lc, rc, pick;
      r.status = bmhq_pkg::STATUS_OK;
      r.key = '0;
      r.payload = '0;
      if (cmd == bmhq_pkg::CMD_INSERT) begin
        if (fill >= bmhq_pkg::CAPACITY) begin
          r.status = bmhq_pkg::STATUS_FULL;
          n_full++;
        end else begin
          i = fill;
          while (i > 0) begin
            up = (i - 1) / 2;
            if (!($signed(key) < $signed(slots[up].key))) break;
            slots[i] = slots[up];
            i = up;
          end
          slots[i].key = key;
          slots[i].payload = payload;
          fill++;
          n_insert++;
          if (fill > peak_fill) peak_fill = fill;
        end
      end else begin
        if (fill == 0) begin
          r.status = bmhq_pkg::STATUS_EMPTY;
          n_empty++;
        end else begin
          last = fill - 1;
          moving = slots[last];
          r.key = slots[0].key;
          r.payload = slots[0].payload;
          i = 0;
          while (2 * i + 1 < last) begin
            lc = 2 * i + 1;
            rc = lc + 1;
            pick = lc;
            if (rc < last && $signed(slots[rc].key) < $signed(slots[lc].key)) pick = rc;
            if (!($signed(slots[pick].key) < $signed(moving.key))) break;
            slots[i] = slots[pick];
            i = pick;
          end
          slots[i] = moving;
          fill = last;
          n_extract++;
        end
      end
      r.now_empty = (fill == 0);
      replies_due = {replies_due, r};
    endfunction

    function void check_reply(logic [bmhq_pkg::STATUS_BITS-1:0] status,
                              logic signed [bmhq_pkg::KEY_BITS-1:0] key,
                              logic [bmhq_pkg::PAYLOAD_BITS-1:0] payload,
                              logic now_empty);
      heap_reply_t want;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result status=%0d key=%0d payload=%h", $time, status,
                 key, payload);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (key !== want.key) begin
        $display("%0t: out_key expected %0d actual %0d", $time, want.key, key);
        errors++;
      end
      if (payload !== want.payload) begin
        $display("%0t: out_payload expected %h actual %h", $time, want.payload, payload);
        errors++;
      end
      if (now_empty !== want.now_empty) begin
        $display("%0t: now_empty expected %0d actual %0d", $time, want.now_empty, now_empty);
        errors++;
      end
    endfunction

    function int pending();
      return replies_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   tx_burst;
  bit   rx_burst;

  bmhq_in_if  in_ch();
  bmhq_out_if out_ch();

  binary_min_heap_queue_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  heap_shadow shadow = new();

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_idle(inout bit burst);
    if ($urandom_range(0, 15) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic signed [bmhq_pkg::KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2: return bmhq_pkg::KEY_BITS'(int'($urandom_range(0, 7)) - 4);
      default: return bmhq_pkg::KEY_BITS'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic signed [bmhq_pkg::KEY_BITS-1:0] key,
                           input logic [bmhq_pkg::PAYLOAD_BITS-1:0] payload);
    int gap;
    gap = draw_idle(tx_burst);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.key     <= key;
    in_ch.payload <= payload;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    shadow.note_command(cmd, key, payload);
  endtask

  task automatic send_random(input int insert_pct);
    logic cmd;
    cmd = ($urandom_range(0, 99) < insert_pct) ? bmhq_pkg::CMD_INSERT : bmhq_pkg::CMD_EXTRACT;
    send_item(cmd, pick_key(), bmhq_pkg::PAYLOAD_BITS'($urandom));
  endtask

  task automatic wait_drained();
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_idle(rx_burst);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      shadow.check_reply(out_ch.status, out_ch.out_key, out_ch.out_payload,
                         out_ch.now_empty);
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = bmhq_pkg::CMD_INSERT;
    in_ch.key     = '0;
    in_ch.payload = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty refusal, extreme keys and payloads, equal keys
    send_item(bmhq_pkg::CMD_EXTRACT, 16'sh1234, 16'hffff);
    send_item(bmhq_pkg::CMD_INSERT, 16'sh7fff, 16'hffff);
    send_item(bmhq_pkg::CMD_INSERT, 16'sh8000, 16'h0000);
    send_item(bmhq_pkg::CMD_INSERT, 16'sh0000, 16'h1234);
    send_item(bmhq_pkg::CMD_INSERT, -16'sd1, 16'h5555);
    send_item(bmhq_pkg::CMD_INSERT, 16'sd5, 16'h000a);
    send_item(bmhq_pkg::CMD_INSERT, 16'sd5, 16'h000b);
    send_item(bmhq_pkg::CMD_INSERT, 16'sd5, 16'h000c);
    send_item(bmhq_pkg::CMD_INSERT, 16'sh8000, 16'hffff);
    send_item(bmhq_pkg::CMD_INSERT, 16'sh5555, 16'haaaa);
    send_item(bmhq_pkg::CMD_INSERT, 16'shaaaa, 16'h5555);
    for (n = 0; n < 11; n++) begin
      send_item(bmhq_pkg::CMD_EXTRACT, pick_key(), bmhq_pkg::PAYLOAD_BITS'($urandom));
    end

    // hold input until every result is back
    in_ch.valid <= 1'b0;
    wait_drained();

    for (n = 0; n < 100; n++) send_random(55);

    // fill to capacity, then push refused inserts
    while (shadow.fill < bmhq_pkg::CAPACITY) send_random(100);
    for (n = 0; n < 3; n++) send_random(100);
    for (n = 0; n < 40; n++) send_random(50);

    // drain to empty, then refused extracts
    while (shadow.fill > 0) send_random(0);
    for (n = 0; n < 2; n++) send_random(0);

    for (n = 0; n < 80; n++) send_random(60);

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);

    $display("Covered %0d inserts, %0d extracts, %0d full and %0d empty refusals.",
             shadow.n_insert, shadow.n_extract, shadow.n_full, shadow.n_empty);
    $display("Heap reached %0d of %0d entries; %0d mismatches seen.", shadow.peak_fill,
             bmhq_pkg::CAPACITY, shadow.errors);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
